// File: rtl/core/mpd_pkg.sv
package mpd_pkg;

   // field widths
   localparam int ChannelWidth = 4;
   localparam int CountWidth   = 17;
   localparam int DivWidth     = 16;
   localparam int StartWidth   = 16;

   // remainder unit: one dividend bit per step
   localparam int DivSteps  = CountWidth;
   localparam int StepWidth = $clog2(DivSteps);

   // configuration register map
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;
   localparam logic [CsrIndexWidth-1:0] CSR_DIVISOR     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_START_COUNT = 2'd1;

   // register reset values
   localparam logic [DivWidth-1:0]          DIVISOR_RESET = 16'd1;
   localparam logic signed [StartWidth-1:0] START_RESET   = -16'sd1;
   localparam logic signed [CountWidth-1:0] COUNT_RESET   = -17'sd1;

   typedef struct packed {
      logic [ChannelWidth-1:0] channel;
      logic                    sample_above_zero;
      logic                    trigger_above_zero;
   } req_type;

   typedef struct packed {
      logic divided_pulse;
      logic remaining_pulse;
   } rsp_type;

   // per-channel stored state
   typedef struct packed {
      logic                         last_above_zero;
      logic signed [CountWidth-1:0] edge_count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic read;
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_negative;
      logic rsp_free;
   } status_type;

endpackage

// File: rtl/core/multichannel_pulse_divider.sv
// Multichannel pulse divider.
// Input channel (req_*): one transfer per sample, naming a channel and carrying
// the sample and trigger flags. Result channel (rsp_*): exactly one transfer
// per input transfer, in order, with the divided and remaining pulses.
// Config channel (csr_*): index 0 writes the divisor, index 1 the start count;
// csr_ready is always high. Write it only while no item is in flight.
// Processing: an item with a non-negative count runs a 17-step restoring remainder
// unit, one dividend bit per cycle, between the state read and the commit; the
// next item is taken only once the previous one has been committed.
// A negative count skips the remainder unit and goes from load to commit.
// Per-channel state sits in a memory with a registered read port.
// Reset: all channels read as count -1 with the sample seen above zero,
// divisor 1, start count -1; no clearing pass is needed.
// A stalled result waits in the output register while the next item is
// already accepted and processed; that item holds in its final step until
// the register frees up.
module multichannel_pulse_divider #(
   parameter int CHANNELS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mpd_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mpd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mpd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [mpd_pkg::CsrDataWidth-1:0]  csr_data
);
   import mpd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   mpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // state memory, remainder unit and output register
   mpd_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: rtl/core/mpd_ctrl.sv
module mpd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mpd_pkg::status_type status,
   output mpd_pkg::cmd_type    cmd
);
   import mpd_pkg::*;

   state_type              state_ff, state_in;
   logic [StepWidth-1:0]   step_ff, step_in;

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            // negative counts skip the remainder
            state_in = status.count_negative ? ST_COMMIT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == StepWidth'(DivSteps - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = status.rsp_free;
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/mpd_datapath.sv
module mpd_datapath #(
   parameter int CHANNELS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mpd_pkg::req_type                     req_data,
   output mpd_pkg::rsp_type                     rsp_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 csr_write,
   input  logic [mpd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [mpd_pkg::CsrDataWidth-1:0]     csr_data,
   input  mpd_pkg::cmd_type                     cmd,
   output mpd_pkg::status_type                  status
);
   import mpd_pkg::*;

   localparam int IdxWidth = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [DivWidth-1:0]          divisor_ff;
   logic signed [StartWidth-1:0] start_ff;
   req_type                      req_ff;
   entry_type                    state_mem [CHANNELS];
   logic [CHANNELS-1:0]          entry_valid_ff;
   entry_type                    rd_entry_ff;
   logic                         rd_valid_ff;
   logic signed [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0]        num_ff;
   logic [DivWidth-1:0]          rem_ff;
   logic                         edge_ff;
   rsp_type                      rsp_ff;
   logic                         rsp_valid_ff;

   logic [IdxWidth-1:0]          ch_idx;
   logic                         chan_ok;
   logic [DivWidth-1:0]          div_eff;
   logic signed [CountWidth-1:0] old_count;
   logic                         old_last;
   logic                         edge_now;
   logic signed [CountWidth-1:0] base_count;
   logic signed [CountWidth-1:0] count_in;
   logic [CountWidth-1:0]        trial;
   logic                         trial_ge;
   logic [DivWidth-1:0]          rem_in;
   logic signed [CountWidth-1:0] final_count;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= DIVISOR_RESET;
         start_ff   <= START_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DIVISOR:     divisor_ff <= csr_data;
            CSR_START_COUNT: start_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // a zero divisor acts as one
   assign div_eff = (divisor_ff == '0) ? DivWidth'(1) : divisor_ff;

   // captured input item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   assign ch_idx  = IdxWidth'(req_ff.channel);
   assign chan_ok = 32'(req_ff.channel) < CHANNELS;

   // per-channel state memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_entry_ff <= state_mem[ch_idx];
      end
      if (cmd.commit && chan_ok) begin
         state_mem[ch_idx] <= '{last_above_zero: req_ff.sample_above_zero,
                                edge_count: final_count};
      end
   end

   // entry valid bits, unwritten entries read as reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (cmd.read) begin
            rd_valid_ff <= entry_valid_ff[ch_idx];
         end
         if (cmd.commit && chan_ok) begin
            entry_valid_ff[ch_idx] <= 1'b1;
         end
      end
   end

   // trigger load and edge increment
   always_comb begin
      old_count  = rd_valid_ff ? rd_entry_ff.edge_count : COUNT_RESET;
      old_last   = rd_valid_ff ? rd_entry_ff.last_above_zero : 1'b1;
      edge_now   = req_ff.sample_above_zero && !old_last;
      base_count = req_ff.trigger_above_zero ? CountWidth'(start_ff) : old_count;
      count_in   = base_count + CountWidth'(edge_now);
   end

   // one restoring remainder step
   always_comb begin
      trial    = {rem_ff, num_ff[CountWidth-1]};
      trial_ge = trial >= CountWidth'(div_eff);
      rem_in   = trial_ge ? DivWidth'(trial - CountWidth'(div_eff)) : trial[DivWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff <= count_in;
         num_ff   <= count_in;
         rem_ff   <= '0;
         edge_ff  <= edge_now;
      end else if (cmd.step) begin
         num_ff <= {num_ff[CountWidth-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign final_count = count_ff[CountWidth-1] ? count_ff : CountWidth'(rem_ff);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.divided_pulse   <= chan_ok && edge_ff && (final_count == '0);
         rsp_ff.remaining_pulse <= chan_ok && edge_ff && (final_count != '0);
      end
   end

   assign rsp_data              = rsp_ff;
   assign rsp_valid             = rsp_valid_ff;
   assign status.count_negative = count_in[CountWidth-1];
   assign status.rsp_free       = !rsp_valid_ff || rsp_ready;

endmodule

// File: rtl/core/mpd_checker.sv
module mpd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mpd_pkg::rsp_type rsp_data
);
   import mpd_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // the two pulses exclude each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.divided_pulse && rsp_data.remaining_pulse))
      else $error("both pulses set");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // no result follows too early after a transfer in while none is pending
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("result too early");

   // reset empties the block
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind multichannel_pulse_divider mpd_checker u_mpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: bench/multichannel_pulse_divider_tb.sv
module multichannel_pulse_divider_tb;
   import mpd_pkg::*;

   localparam int Channels = 16;
   localparam int Latency  = 20;
   localparam int PhaseItems = 150;
   localparam int Phases   = 12;

   // register indexes past the map, writes to them are dropped
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_HI = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data  = '0;

   // predicted registers and per-channel state
   logic [15:0]        div_cfg   = DIVISOR_RESET;
   logic signed [15:0] start_cfg = START_RESET;
   int                 chan_count [Channels];
   bit                 chan_last [Channels];

   rsp_type pulses_due [$];
   rsp_type due_pulse;
   int      mismatches = 0;
   int      burst_left = 1;

   // receiver stall pattern
   logic [15:0] stall_mask  = '1;
   int          pattern_age = 0;

   multichannel_pulse_divider #(.CHANNELS(Channels)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      for (int c = 0; c < Channels; c++) begin
         chan_count[c] = -1;
         chan_last[c]  = 1'b1;
      end
   end

   // expected pulses for one sample, updates the channel state
   function automatic rsp_type advance_channel(req_type item);
      int      count;
      int      modulus;
      bit      rise;
      rsp_type pulses;
      pulses = '0;
      if (item.channel >= Channels) return pulses;
      modulus = (div_cfg == 16'd0) ? 1 : int'(div_cfg);
      count = chan_count[item.channel];
      if (item.trigger_above_zero) count = int'(start_cfg);
      rise = item.sample_above_zero && !chan_last[item.channel];
      if (rise) count++;
      if (count >= 0) count = count % modulus;
      chan_count[item.channel] = count;
      chan_last[item.channel]  = item.sample_above_zero;
      pulses.divided_pulse   = rise && (count == 0);
      pulses.remaining_pulse = rise && (count != 0);
      return pulses;
   endfunction

   task automatic flag_failure(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected divided=%b remaining=%b, got divided=%b remaining=%b",
                  $realtime, what, want.divided_pulse, want.remaining_pulse,
                  got.divided_pulse, got.remaining_pulse);
   endtask

   // one input transfer, then either stay in the burst or idle a while
   task automatic send_sample(input int ch, input bit sample, input bit trigger);
      req_type item;
      item.channel            = ch[ChannelWidth-1:0];
      item.sample_above_zero  = sample;
      item.trigger_above_zero = trigger;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pulses_due.push_back(advance_channel(item));
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 8);
      end
   endtask

   // register write, valid is lowered by the caller after the last one
   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_DIVISOR:     div_cfg = value;
         CSR_START_COUNT: start_cfg = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] divisor, input logic [15:0] start);
      write_register(CSR_DIVISOR, divisor);
      write_register(CSR_START_COUNT, start);
      csr_valid <= 1'b0;
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pulses_due.size() != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   // reset values: count -1, sample seen high, divisor 1, start -1
   task automatic test_reset_defaults();
      send_sample(0, 1'b1, 1'b0);
      send_sample(0, 1'b0, 1'b0);
      send_sample(0, 1'b1, 1'b0);
      send_sample(15, 1'b0, 1'b1);
      send_sample(15, 1'b1, 1'b0);
      send_sample(5, 1'b0, 1'b0);
      send_sample(5, 1'b1, 1'b1);
      send_sample(10, 1'b1, 1'b1);
   endtask

   // zero divisor, start extremes, widest count, writes past the map
   task automatic test_register_extremes();
      settle_pipeline();
      configure(16'd0, 16'h7fff);
      send_sample(3, 1'b0, 1'b1);
      send_sample(3, 1'b1, 1'b0);
      settle_pipeline();
      configure(16'hffff, 16'h8000);
      send_sample(7, 1'b0, 1'b1);
      send_sample(7, 1'b1, 1'b0);
      settle_pipeline();
      configure(16'hffff, 16'h7fff);
      send_sample(8, 1'b0, 1'b1);
      send_sample(8, 1'b1, 1'b1);
      send_sample(8, 1'b0, 1'b0);
      send_sample(8, 1'b1, 1'b0);
      settle_pipeline();
      write_register(CSR_SPARE_LO, 16'h0000);
      write_register(CSR_SPARE_HI, 16'hffff);
      csr_valid <= 1'b0;
      send_sample(9, 1'b0, 1'b1);
      send_sample(9, 1'b1, 1'b0);
   endtask

   // pulse trains on a few busy channels under changing settings
   task automatic test_random_trains();
      int          ch;
      bit          sample;
      logic [15:0] divisor;
      logic [15:0] start;
      for (int p = 0; p < Phases; p++) begin
         settle_pipeline();
         case ($urandom_range(0, 5))
            0: divisor = 16'd0;
            1: divisor = 16'd1;
            2: divisor = 16'hffff;
            3: divisor = 16'($urandom);
            default: divisor = 16'($urandom_range(2, 6));
         endcase
         case ($urandom_range(0, 4))
            0: start = 16'h8000;
            1: start = 16'h7fff;
            2: start = 16'($urandom);
            default: start = 16'($urandom_range(0, 10) - 5);
         endcase
         if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
         configure(divisor, start);
         for (int i = 0; i < PhaseItems; i++) begin
            ch = ($urandom_range(0, 2) == 0) ? $urandom_range(0, Channels - 1)
                                             : $urandom_range(0, 3);
            sample = ($urandom_range(0, 4) != 0) ? !chan_last[ch] : 1'($urandom);
            send_sample(ch, sample, $urandom_range(0, 11) == 0);
         end
      end
   endtask

   // receiver stalls on a rotating mask, sometimes all ready
   always @(posedge clock) begin
      if (pattern_age == 0) begin
         pattern_age <= $urandom_range(32, 200);
         stall_mask  <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end else begin
         pattern_age <= pattern_age - 1;
         stall_mask  <= {stall_mask[0], stall_mask[15:1]};
      end
      rsp_ready <= stall_mask[0];
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pulses_due.size() == 0) begin
            flag_failure("result with nothing outstanding", '0, rsp_data);
         end else begin
            due_pulse = pulses_due.pop_front();
            if (due_pulse.divided_pulse !== rsp_data.divided_pulse ||
                due_pulse.remaining_pulse !== rsp_data.remaining_pulse)
               flag_failure("pulse mismatch", due_pulse, rsp_data);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_random_trains();
      settle_pipeline();
      if (pulses_due.size() != 0)
         flag_failure("results never arrived", pulses_due[0], '0);
      if (mismatches == 0) begin
         $display("multichannel_pulse_divider_tb: PASS");
      end else begin
         $display("multichannel_pulse_divider_tb: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("multichannel_pulse_divider_tb: FAIL");
      $finish;
   end

endmodule
